// ===== hw/rtl/isc_pkg.sv =====
// ----------------------------------------------------------------------------
// isc_pkg
// shared types and constants for the integration scale select block
// ----------------------------------------------------------------------------
`default_nettype none

package isc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ROOT_W = 32;
	localparam int RAD_W = 64;
	localparam int DIST_W = 35;
	localparam logic [DIST_W-1:0] QUARTER = DIST_W'(1) << (FRAC_BITS - 2);

	localparam logic REG_SENSOR_MODE = 1'b0;
	localparam logic REG_PIXEL_SIZE = 1'b1;

	localparam logic [31:0] PIXEL_RESET = 32'd2097152;

	typedef struct packed {
		logic signed [31:0] z;
		logic [30:0] voxel;
		logic [1:0] prev;
		logic [1:0] limit;
		logic hyst;
	} side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/integration_scale_select_core.sv =====
// ----------------------------------------------------------------------------
// integration_scale_select_core
// level-of-detail scale selection for a voxel block with optional hysteresis
// one item accepted every cycle, busy is never high
// the 32-stage square root pipeline computes the lidar range
// reset clears the valid bits and the registers to mode 0 and pixel size 2097152
// ----------------------------------------------------------------------------
`default_nettype none

module integration_scale_select_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic signed [31:0] centre_x,
	input  wire logic signed [31:0] centre_y,
	input  wire logic signed [31:0] centre_z,
	input  wire logic [30:0] voxel_size,
	input  wire logic [1:0] previous_scale,
	input  wire logic [1:0] scale_limit,
	input  wire logic hysteresis_on,
	output logic done,
	output logic [1:0] chosen_scale,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic cfg_index,
	input  wire logic [31:0] cfg_data
);
	import isc_pkg::*;

	logic mode_q;
	logic [31:0] pixel_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			pixel_q <= PIXEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SENSOR_MODE: mode_q <= cfg_data[0];
				REG_PIXEL_SIZE: pixel_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// magnitudes, squares, sum
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [31:0] ax_s1, ay_s1, az_s1;
	logic [63:0] sx_s2, sy_s2, sz_s2;
	logic [RAD_W-1:0] sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1 <= centre_x[31] ? 32'(-centre_x) : 32'(centre_x);
		ay_s1 <= centre_y[31] ? 32'(-centre_y) : 32'(centre_y);
		az_s1 <= centre_z[31] ? 32'(-centre_z) : 32'(centre_z);
		side_s1 <= '{z: centre_z, voxel: voxel_size, prev: previous_scale,
			limit: scale_limit, hyst: hysteresis_on};
		sx_s2 <= 64'(ax_s1) * 64'(ax_s1);
		sy_s2 <= 64'(ay_s1) * 64'(ay_s1);
		sz_s2 <= 64'(az_s1) * 64'(az_s1);
		side_s2 <= side_s1;
		sum_s3 <= sx_s2 + sy_s2 + sz_s2;
		side_s3 <= side_s2;
	end

	logic rt_vld;
	logic [ROOT_W-1:0] rt;
	side_t rt_side;

	isc_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(vld_s3),
		.rad(sum_s3),
		.in_side(side_s3),
		.out_vld(rt_vld),
		.root(rt),
		.out_side(rt_side)
	);

	// candidate distances
	logic signed [DIST_W-1:0] d0;
	logic signed [DIST_W-1:0] dm;
	logic signed [DIST_W-1:0] d0_s4, dm_s4, dp_s4;
	assign d0 = mode_q ? $signed(DIST_W'(rt)) : DIST_W'(rt_side.z);
	assign dm = d0 - $signed(QUARTER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s4 <= rt_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			done <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		d0_s4 <= d0;
		dm_s4 <= (mode_q && dm[DIST_W-1]) ? -dm : dm;
		dp_s4 <= d0 + $signed(QUARTER);
		side_s4 <= rt_side;
		side_s5 <= side_s4;
		side_s6 <= side_s5;
	end

	logic [1:0] lv0, lvm, lvp;

	isc_level u_lv0 (.clk(clk), .depth(d0_s4), .voxel(side_s4.voxel),
		.limit(side_s4.limit), .lidar(mode_q), .pixel(pixel_q), .level(lv0));
	isc_level u_lvm (.clk(clk), .depth(dm_s4), .voxel(side_s4.voxel),
		.limit(side_s4.limit), .lidar(mode_q), .pixel(pixel_q), .level(lvm));
	isc_level u_lvp (.clk(clk), .depth(dp_s4), .voxel(side_s4.voxel),
		.limit(side_s4.limit), .lidar(mode_q), .pixel(pixel_q), .level(lvp));

	always_ff @(posedge clk) begin
		if (side_s6.hyst && (lv0 != side_s6.prev)) begin
			chosen_scale <= (lv0 > side_s6.prev) ? lvm : lvp;
		end else begin
			chosen_scale <= lv0;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/isc_sqrt.sv =====
// ----------------------------------------------------------------------------
// isc_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module isc_sqrt (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_vld,
	input  wire logic [isc_pkg::RAD_W-1:0] rad,
	input  isc_pkg::side_t in_side,
	output logic out_vld,
	output logic [isc_pkg::ROOT_W-1:0] root,
	output isc_pkg::side_t out_side
);
	import isc_pkg::*;

	logic [RAD_W-1:0] rem_s [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	logic vld_s [0:ROOT_W];
	side_t side_s [0:ROOT_W];

	assign rem_s[0] = rad;
	assign root_s[0] = '0;
	assign vld_s[0] = in_vld;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int B = ROOT_W - 1 - k;
		logic [RAD_W+1:0] trial;
		logic take;
		assign trial = ((RAD_W+2)'(root_s[k]) << (B + 1)) + ((RAD_W+2)'(1) << (2 * B));
		assign take = (RAD_W+2)'(rem_s[k]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= take ? RAD_W'((RAD_W+2)'(rem_s[k]) - trial) : rem_s[k];
			root_s[k+1] <= take ? (root_s[k] | (ROOT_W'(1) << B)) : root_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_vld = vld_s[ROOT_W];
	assign root = root_s[ROOT_W];
	assign out_side = side_s[ROOT_W];

endmodule

`default_nettype wire

// ===== hw/rtl/isc_level.sv =====
// ----------------------------------------------------------------------------
// isc_level
// two-stage scale evaluation for one distance: multiply, compare, clamp
// ----------------------------------------------------------------------------
`default_nettype none

module isc_level (
	input  wire logic clk,
	input  wire logic signed [isc_pkg::DIST_W-1:0] depth,
	input  wire logic [30:0] voxel,
	input  wire logic [1:0] limit,
	input  wire logic lidar,
	input  wire logic [31:0] pixel,
	output logic [1:0] level
);
	import isc_pkg::*;

	logic pos_s1;
	logic [48:0] pp_lo_s1;
	logic [47:0] pp_hi_s1;
	logic [32:0] kv_s1;
	logic [1:0] limit_s1;

	logic [32:0] du;
	logic [32:0] kv;
	assign du = depth[32:0];
	assign kv = lidar ? (33'(voxel) << 1) : (33'(voxel) + (33'(voxel) << 1));

	always_ff @(posedge clk) begin
		pos_s1 <= !depth[DIST_W-1] && (depth != '0);
		pp_lo_s1 <= 49'(du[16:0]) * 49'(pixel);
		pp_hi_s1 <= 48'(du[32:17]) * 48'(pixel);
		kv_s1 <= kv;
		limit_s1 <= limit;
	end

	logic [65:0] lhs;
	logic [65:0] lhs2;
	logic [1:0] cnt;
	logic [1:0] sel;
	assign lhs = (66'(pp_hi_s1) << 17) + 66'(pp_lo_s1);
	assign lhs2 = lhs << 1;

	always_comb begin
		cnt = 2'd0;
		if (pos_s1) begin
			if (lhs2 >= (66'(kv_s1) << 32)) begin
				cnt = 2'd3;
			end else if (lhs2 >= (66'(kv_s1) << 31)) begin
				cnt = 2'd2;
			end else if (lhs2 >= (66'(kv_s1) << 30)) begin
				cnt = 2'd1;
			end
		end
		sel = (cnt < limit_s1) ? cnt : limit_s1;
	end

	always_ff @(posedge clk) begin
		level <= sel;
	end

endmodule

`default_nettype wire
